@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`define RPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define RPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/rpd_pkg.sv @@
// Package: widths, limits and result kind codes of the request deframer.
`timescale 1ns / 1ps

package rpd_pkg;

  localparam int BYTE_W           = 8;
  localparam int VALUE_W          = 32;
  localparam int IDX_W            = 8;
  localparam int KIND_W           = 3;

  localparam int LENGTH_BITS      = 32;
  localparam int MAX_LENGTH_BYTES = 4;

  // Bits a decoded length may occupy; anything outside is a format error.
  localparam logic [VALUE_W-1:0] LEN_MASK = VALUE_W'((64'd1 << LENGTH_BITS) - 64'd1);

  typedef enum logic [KIND_W-1:0] {
    KIND_TYPE    = 3'd0,
    KIND_SERVICE = 3'd1,
    KIND_METHOD  = 3'd2,
    KIND_COUNT   = 3'd3,
    KIND_LENGTH  = 3'd4,
    KIND_DATA    = 3'd5,
    KIND_ERROR   = 3'd6
  } kind_t;

endpackage

@@ rtl/rpd_byte_if.sv @@
// Channel interfaces: raw stream words in, decoded result words out.
`timescale 1ns / 1ps

interface rpd_byte_if import rpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface rpd_result_if import rpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;
  logic [IDX_W-1:0]   arg_index;
  logic               end_of_request;

  modport source (output valid, output kind, output value, output arg_index,
                  output end_of_request, input ready);
  modport sink   (input valid, input kind, input value, input arg_index,
                  input end_of_request, output ready);
endinterface

@@ rtl/rpc_request_deframer.sv @@
// Top level: request stream deframer with BER-style argument length prefixes.
//
//  channel     dir  payload                                   handshake
//  in_byte     in   data_byte[7:0]                            valid/ready
//  out_result  out  kind[2:0] value[31:0] arg_index[7:0] eor  valid/ready
//
// One word is taken per cycle while in_byte.ready is high; its result (if any)
// goes to the output register. Only a long prefix's last length byte gives one.
// in_byte.ready drops only while a result is held and out_result.ready is low.
// Reset is synchronous (rst_n low): parser returns to expecting a type word.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rpc_request_deframer import rpd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  rpd_byte_if.sink     in_byte,
  rpd_result_if.source out_result
);

  typedef enum logic [6:0] {
    PH_TYPE     = 7'b0000001,
    PH_SERVICE  = 7'b0000010,
    PH_METHOD   = 7'b0000100,
    PH_COUNT    = 7'b0001000,
    PH_PREFIX   = 7'b0010000,
    PH_LENBYTES = 7'b0100000,
    PH_DATA     = 7'b1000000
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [IDX_W-1:0]   args_total_r, args_total_nxt;
  logic [IDX_W-1:0]   cur_arg_r, cur_arg_nxt;
  logic [2:0]         len_left_r, len_left_nxt;
  logic [VALUE_W-1:0] len_accum_r, len_accum_nxt;
  logic [VALUE_W-1:0] data_left_r, data_left_nxt;

  logic               out_valid_r;
  kind_t              kind_r;
  logic [VALUE_W-1:0] value_r;
  logic [IDX_W-1:0]   arg_index_r;
  logic               eor_r;

  logic               in_acc;
  logic [BYTE_W-1:0]  b;

  logic               res_vld;
  kind_t              res_kind;
  logic [VALUE_W-1:0] res_value;
  logic [IDX_W-1:0]   res_idx;
  logic               res_eor;

  logic               fin_req;
  logic [VALUE_W-1:0] fin_len;
  logic [VALUE_W-1:0] accum_shift;
  logic [IDX_W:0]     arg_inc;
  logic               arg_last;

  assign b        = in_byte.data_byte;
  assign in_byte.ready = !out_valid_r || out_result.ready;
  assign in_acc   = in_byte.valid && in_byte.ready;

  assign out_result.valid          = out_valid_r;
  assign out_result.kind           = kind_r;
  assign out_result.value          = value_r;
  assign out_result.arg_index      = arg_index_r;
  assign out_result.end_of_request = eor_r;

  // Closing the current argument ends the frame when it was the last one.
  assign arg_inc     = {1'b0, cur_arg_r} + {{IDX_W{1'b0}}, 1'b1};
  assign arg_last    = (arg_inc[IDX_W-1:0] == args_total_r) ||
                       (arg_inc >= {1'b0, args_total_r});
  assign accum_shift = {len_accum_r[VALUE_W-BYTE_W-1:0], b};

  always_comb begin
    phase_nxt      = phase_r;
    args_total_nxt = args_total_r;
    cur_arg_nxt    = cur_arg_r;
    len_left_nxt   = len_left_r;
    len_accum_nxt  = len_accum_r;
    data_left_nxt  = data_left_r;
    res_vld        = 1'b0;
    res_kind       = KIND_TYPE;
    res_value      = VALUE_W'(b);
    res_idx        = '0;
    res_eor        = 1'b0;
    fin_req        = 1'b0;
    fin_len        = '0;

    case (phase_r)
      PH_SERVICE: begin
        phase_nxt = PH_METHOD;
        res_vld   = 1'b1;
        res_kind  = KIND_SERVICE;
      end
      PH_METHOD: begin
        phase_nxt = PH_COUNT;
        res_vld   = 1'b1;
        res_kind  = KIND_METHOD;
      end
      PH_COUNT: begin
        args_total_nxt = b;
        cur_arg_nxt    = '0;
        res_vld        = 1'b1;
        res_kind       = KIND_COUNT;
        if (b == '0) begin
          phase_nxt = PH_TYPE;
          res_eor   = 1'b1;
        end else begin
          phase_nxt = PH_PREFIX;
        end
      end
      PH_PREFIX: begin
        if (!b[7]) begin
          fin_req = 1'b1;
          fin_len = VALUE_W'(b);
        end else if (b[3:0] > 4'(MAX_LENGTH_BYTES)) begin
          phase_nxt   = PH_TYPE;
          cur_arg_nxt = '0;
          res_vld     = 1'b1;
          res_kind    = KIND_ERROR;
          res_idx     = cur_arg_r;
          res_eor     = 1'b1;
        end else if (b[3:0] == 4'd0) begin
          fin_req = 1'b1;
        end else begin
          len_left_nxt  = b[2:0];
          len_accum_nxt = '0;
          phase_nxt     = PH_LENBYTES;
        end
      end
      PH_LENBYTES: begin
        len_accum_nxt = accum_shift;
        len_left_nxt  = len_left_r - 3'd1;
        if (len_left_nxt == 3'd0) begin
          fin_req = 1'b1;
          fin_len = accum_shift;
        end
      end
      PH_DATA: begin
        data_left_nxt = data_left_r - VALUE_W'(1);
        res_vld       = 1'b1;
        res_kind      = KIND_DATA;
        res_idx       = cur_arg_r;
        if (data_left_nxt == '0) begin
          res_eor = arg_last;
          if (arg_last) begin
            phase_nxt   = PH_TYPE;
            cur_arg_nxt = '0;
          end else begin
            phase_nxt   = PH_PREFIX;
            cur_arg_nxt = arg_inc[IDX_W-1:0];
          end
        end
      end
      default: begin
        phase_nxt = PH_SERVICE;
        res_vld   = 1'b1;
        res_kind  = KIND_TYPE;
      end
    endcase

    // A complete length: too wide, zero, or the start of a data run.
    if (fin_req) begin
      res_vld   = 1'b1;
      res_idx   = cur_arg_r;
      res_value = fin_len;
      if ((fin_len & ~LEN_MASK) != '0) begin
        phase_nxt   = PH_TYPE;
        cur_arg_nxt = '0;
        res_kind    = KIND_ERROR;
        res_eor     = 1'b1;
      end else if (fin_len == '0) begin
        res_kind = KIND_LENGTH;
        res_eor  = arg_last;
        if (arg_last) begin
          phase_nxt   = PH_TYPE;
          cur_arg_nxt = '0;
        end else begin
          phase_nxt   = PH_PREFIX;
          cur_arg_nxt = arg_inc[IDX_W-1:0];
        end
      end else begin
        res_kind      = KIND_LENGTH;
        data_left_nxt = fin_len;
        phase_nxt     = PH_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TYPE;
      args_total_r <= '0;
      cur_arg_r    <= '0;
      len_left_r   <= '0;
      len_accum_r  <= '0;
      data_left_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r      <= phase_nxt;
        args_total_r <= args_total_nxt;
        cur_arg_r    <= cur_arg_nxt;
        len_left_r   <= len_left_nxt;
        len_accum_r  <= len_accum_nxt;
        data_left_r  <= data_left_nxt;
      end
      if (in_acc && res_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_result.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_vld) begin
      kind_r      <= res_kind;
      value_r     <= res_value;
      arg_index_r <= res_idx;
      eor_r       <= res_eor;
    end
  end

  `RPD_ASSERT_IMPLY(a_err_ends_frame, clk, rst_n, out_valid_r && kind_r == KIND_ERROR, eor_r, "format error result without end of request")
  `RPD_ASSERT_IMPLY(a_hdr_idx_zero, clk, rst_n, out_valid_r && (kind_r == KIND_TYPE || kind_r == KIND_SERVICE || kind_r == KIND_METHOD || kind_r == KIND_COUNT), arg_index_r == '0, "header result with nonzero argument index")
  `RPD_ASSERT_NEXT(a_eor_resync, clk, rst_n, in_acc && res_vld && res_eor, phase_r == PH_TYPE && cur_arg_r == '0, "parser not back at type word after end of request")

endmodule
